### src/jn2u_pkg.sv
// ----------------------------------------------------------------------------
// jn2u_pkg
// Shared types and constants for the Joliet name to UTF-8 converter.
// ----------------------------------------------------------------------------
package jn2u_pkg;

    // byte budget of one name
    localparam logic [7:0] NAME_LIMIT = 8'd128;

    // code unit classes
    localparam logic [15:0] ASCII_MAX      = 16'h007f;
    localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;

    // utf-8 framing
    localparam logic [7:0] LEAD3     = 8'he0;
    localparam logic [7:0] LEAD2     = 8'hc0;
    localparam logic [7:0] CONT      = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'h3f;

    // suffix and dot characters
    localparam logic [7:0] CHAR_SEMI = 8'h3b;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_DOT  = 8'h2e;

    // result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_LENGTH = 1'b1;

    // command queue depth
    localparam int CMD_DEPTH = 2;

    // work for the back end: up to three bytes and an optional length report
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       last;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic       kind;
        logic [7:0] position;
        logic [7:0] byte_value;
        logic [7:0] name_length;
        logic       run_end;
    } t_res;

endpackage

### src/jn2u_front.sv
// ----------------------------------------------------------------------------
// jn2u_front
// Accepts code units, applies zero stop and byte budget, and issues commands.
// ----------------------------------------------------------------------------
module jn2u_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [15:0]   i_code_unit,
    input  logic          i_last,
    input  logic          i_q_full,
    output logic          o_cmd_push,
    output jn2u_pkg::t_cmd o_cmd
);
    import jn2u_pkg::*;

    logic       r_halted;
    logic       n_halted;
    logic [7:0] r_budget;
    logic [7:0] n_budget;
    logic       accept;
    logic       is_ascii;
    logic       is_three;
    logic [7:0] need;
    t_cmd       cmd;

    assign accept   = i_push && !i_q_full;
    assign is_ascii = (i_code_unit <= ASCII_MAX);
    assign is_three = (i_code_unit >= THREE_BYTE_MIN);
    assign need     = is_three ? 8'd3 : 8'd2;

    // classify the unit and build the command
    always_comb begin
        n_halted = r_halted;
        n_budget = r_budget;
        cmd.cnt  = 2'd0;
        cmd.b0   = 8'h00;
        cmd.b1   = 8'h00;
        cmd.b2   = 8'h00;
        cmd.last = i_last;
        if (!r_halted && i_code_unit == 16'h0000) begin
            n_halted = 1'b1;
        end else if (!r_halted && r_budget != 8'd0) begin
            if (is_ascii) begin
                cmd.cnt  = 2'd1;
                cmd.b0   = i_code_unit[7:0];
                n_budget = r_budget - 8'd1;
            end else if (need > r_budget) begin
                n_budget = r_budget - 8'd1;
            end else if (is_three) begin
                cmd.cnt  = 2'd3;
                cmd.b0   = LEAD3 | {4'h0, i_code_unit[15:12]};
                cmd.b1   = CONT | ({2'b00, i_code_unit[11:6]} & CONT_MASK);
                cmd.b2   = CONT | ({2'b00, i_code_unit[5:0]} & CONT_MASK);
                n_budget = r_budget - 8'd3;
            end else begin
                cmd.cnt  = 2'd2;
                cmd.b0   = LEAD2 | {3'b000, i_code_unit[10:6]};
                cmd.b1   = CONT | ({2'b00, i_code_unit[5:0]} & CONT_MASK);
                n_budget = r_budget - 8'd2;
            end
        end
        // last unit starts a fresh name
        if (i_last) begin
            n_halted = 1'b0;
            n_budget = NAME_LIMIT;
        end
    end

    assign o_cmd_push = accept && (cmd.cnt != 2'd0 || i_last);
    assign o_cmd      = cmd;

    // budget and stop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted <= 1'b0;
            r_budget <= NAME_LIMIT;
        end else if (accept) begin
            r_halted <= n_halted;
            r_budget <= n_budget;
        end
    end

endmodule

### src/jn2u_cmd_queue.sv
// ----------------------------------------------------------------------------
// jn2u_cmd_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module jn2u_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jn2u_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output jn2u_pkg::t_cmd o_cmd
);
    import jn2u_pkg::*;

    localparam int PtrW = $clog2(CMD_DEPTH);
    localparam int CntW = $clog2(CMD_DEPTH + 1);

    t_cmd            r_mem [CMD_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/jn2u_back.sv
// ----------------------------------------------------------------------------
// jn2u_back
// Expands commands into result items held in an output queue, one per cycle
// while it has room, and tracks the written bytes and trailing suffix state.
// ----------------------------------------------------------------------------
module jn2u_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  jn2u_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output jn2u_pkg::t_res o_res
);
    import jn2u_pkg::*;

    // expansion state
    logic [1:0] r_step;
    logic [7:0] r_count;
    // end of last non-dot byte for the current length and the two before
    logic [7:0] r_p0;
    logic [7:0] r_p1;
    logic [7:0] r_p2;
    // last and second-to-last written bytes
    logic [7:0] r_b0;
    logic [7:0] r_b1;

    // output queue
    t_res       r_oq [2];
    logic       r_oq_wr;
    logic       r_oq_rd;
    logic [1:0] r_oq_count;

    logic       oq_has_room;
    logic       oq_pop;
    logic       fire;
    logic       emit_byte;
    logic [7:0] cur_byte;
    logic       semi;
    logic [7:0] base_len;
    logic [7:0] base_p;
    logic [7:0] final_len;
    t_res       res;

    assign oq_has_room = (r_oq_count != 2'd2);
    assign oq_pop      = i_pop && (r_oq_count != 2'd0);
    assign fire        = i_cmd_valid && oq_has_room;
    assign emit_byte   = (r_step < i_cmd.cnt);

    // byte select for this step
    always_comb begin
        case (r_step)
            2'd0:    cur_byte = i_cmd.b0;
            2'd1:    cur_byte = i_cmd.b1;
            default: cur_byte = i_cmd.b2;
        endcase
    end

    // final length after suffix and dot stripping
    always_comb begin
        semi     = (r_count > 8'd2) && (r_b1 == CHAR_SEMI) && (r_b0 == CHAR_ONE);
        base_len = semi ? (r_count - 8'd2) : r_count;
        base_p   = semi ? r_p2 : r_p0;
        if (base_len == 8'd0) begin
            final_len = 8'd0;
        end else if (base_p == 8'd0) begin
            final_len = 8'd1;
        end else begin
            final_len = base_p;
        end
    end

    // result for this cycle
    always_comb begin
        if (emit_byte) begin
            res.kind        = KIND_BYTE;
            res.position    = r_count;
            res.byte_value  = cur_byte;
            res.name_length = 8'd0;
            res.run_end     = (r_step == i_cmd.cnt - 2'd1) && !i_cmd.last;
        end else begin
            res.kind        = KIND_LENGTH;
            res.position    = 8'd0;
            res.byte_value  = 8'd0;
            res.name_length = final_len;
            res.run_end     = 1'b1;
        end
    end

    assign o_cmd_pop = fire && (emit_byte ? ((r_step == i_cmd.cnt - 2'd1) && !i_cmd.last)
                                          : 1'b1);

    // step counter and name tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 2'd0;
            r_count <= 8'd0;
            r_p0    <= 8'd0;
            r_p1    <= 8'd0;
            r_p2    <= 8'd0;
        end else if (fire) begin
            if (emit_byte) begin
                r_count <= r_count + 8'd1;
                r_p0    <= (cur_byte != CHAR_DOT) ? r_count + 8'd1 : r_p0;
                r_p1    <= r_p0;
                r_p2    <= r_p1;
                r_step  <= o_cmd_pop ? 2'd0 : r_step + 2'd1;
            end else begin
                r_step  <= 2'd0;
                r_count <= 8'd0;
                r_p0    <= 8'd0;
                r_p1    <= 8'd0;
                r_p2    <= 8'd0;
            end
        end
    end

    // trailing byte history
    always_ff @(posedge i_clk) begin
        if (fire && emit_byte) begin
            r_b0 <= cur_byte;
            r_b1 <= r_b0;
        end
    end

    // output queue storage
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_oq[r_oq_wr] <= res;
        end
    end

    // output queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr    <= 1'b0;
            r_oq_rd    <= 1'b0;
            r_oq_count <= 2'd0;
        end else begin
            if (fire) begin
                r_oq_wr <= ~r_oq_wr;
            end
            if (oq_pop) begin
                r_oq_rd <= ~r_oq_rd;
            end
            if (fire && !oq_pop) begin
                r_oq_count <= r_oq_count + 2'd1;
            end else if (oq_pop && !fire) begin
                r_oq_count <= r_oq_count - 2'd1;
            end
        end
    end

    assign o_empty = (r_oq_count == 2'd0);
    assign o_res   = r_oq[r_oq_rd];

endmodule

### src/joliet_name_to_utf8_top.sv
// ----------------------------------------------------------------------------
// joliet_name_to_utf8_top
// Converts UCS-2 Joliet name units to UTF-8 bytes with positions and
// reports the stripped name length on the last unit.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------------
//   input    | i_push / o_full  | i_code_unit, i_last
//   result   | o_empty / i_pop  | o_kind, o_position, o_byte_value,
//            |                  | o_name_length, o_run_end
//
// A unit is taken every cycle while the two-entry command queue has room.
// The back end emits one result per cycle while its output queue has room:
// a unit yields one result per UTF-8 byte, plus one for the length if last.
// A unit that writes nothing and is not last is not passed to the back end.
// Results leave through a two-entry output queue; pop stalls reach the input
// only once both queues are full. Reset is synchronous and needs no clearing.
// ----------------------------------------------------------------------------
module joliet_name_to_utf8_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_code_unit,
    input  logic        i_last,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_kind,
    output logic [7:0]  o_position,
    output logic [7:0]  o_byte_value,
    output logic [7:0]  o_name_length,
    output logic        o_run_end
);
    import jn2u_pkg::*;

    logic cmd_push;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    t_cmd cmd_in;
    t_cmd cmd_out;
    t_res res;

    // front end
    jn2u_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_code_unit (i_code_unit),
        .i_last      (i_last),
        .i_q_full    (cmd_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    // command queue
    jn2u_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    // back end
    jn2u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_res       (res)
    );

    assign o_full        = cmd_full;
    assign o_kind        = res.kind;
    assign o_position    = res.position;
    assign o_byte_value  = res.byte_value;
    assign o_name_length = res.name_length;
    assign o_run_end     = res.run_end;

    // checks
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd_push && cmd_full))
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd_pop && cmd_empty))
        else $error("command popped from empty queue");

    a_length_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind == KIND_LENGTH) |-> (o_run_end && o_position == 8'd0))
        else $error("length result malformed");

    a_byte_in_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind == KIND_BYTE) |-> (o_position < NAME_LIMIT))
        else $error("byte position beyond budget");

endmodule
